>>> design/aks_pkg.sv
// aks_pkg: shared types, constants and tables of the AES-128 key schedule.
// Holds the S-box and round constant tables; depends on nothing.
package aks_pkg;

	localparam int unsigned AKS_HALF_W      = 64;
	localparam int unsigned AKS_ROUND_W     = 4;
	localparam int unsigned AKS_QUEUE_DEPTH = 2;

	localparam logic [AKS_ROUND_W-1:0] AKS_ROUND_FIRST = 4'd0;
	localparam logic [AKS_ROUND_W-1:0] AKS_ROUND_LAST  = 4'd10;

	typedef struct packed {
		logic [AKS_HALF_W-1:0] key_high;
		logic [AKS_HALF_W-1:0] key_low;
	} aks_key_t;

	localparam logic [7:0] AKS_SBOX [256] = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
	};

	// Round constant used to build round (idx + 1).
	function automatic logic [7:0] aks_rcon(input logic [AKS_ROUND_W-1:0] idx);
		logic [7:0] rc;
		case (idx)
			4'd0:    rc = 8'h01;
			4'd1:    rc = 8'h02;
			4'd2:    rc = 8'h04;
			4'd3:    rc = 8'h08;
			4'd4:    rc = 8'h10;
			4'd5:    rc = 8'h20;
			4'd6:    rc = 8'h40;
			4'd7:    rc = 8'h80;
			4'd8:    rc = 8'h1b;
			4'd9:    rc = 8'h36;
			default: rc = 8'h00;
		endcase
		return rc;
	endfunction

endpackage

>>> design/aks_if.sv
// aks_if: valid/ready channel interfaces for cipher keys and round keys.
// Depends on aks_pkg for field widths.
interface aks_key_if;
	logic                           valid;
	logic                           ready;
	logic [aks_pkg::AKS_HALF_W-1:0] key_high;
	logic [aks_pkg::AKS_HALF_W-1:0] key_low;

	modport source (output valid, output key_high, output key_low, input ready);
	modport sink   (input valid, input key_high, input key_low, output ready);
endinterface

interface aks_rk_if;
	logic                            valid;
	logic                            ready;
	logic [aks_pkg::AKS_ROUND_W-1:0] round_number;
	logic [aks_pkg::AKS_HALF_W-1:0]  round_key_high;
	logic [aks_pkg::AKS_HALF_W-1:0]  round_key_low;
	logic                            final_round;

	modport source (output valid, output round_number, output round_key_high,
		output round_key_low, output final_round, input ready);
	modport sink   (input valid, input round_number, input round_key_high,
		input round_key_low, input final_round, output ready);
endinterface

>>> design/aks_front.sv
// aks_front: takes cipher key requests and holds them in a short queue.
// Depends on aks_pkg and aks_key_if.
module aks_front #(
	parameter int unsigned QUEUE_DEPTH = aks_pkg::AKS_QUEUE_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	aks_key_if.sink           keys,
	output logic              q_valid,
	output aks_pkg::aks_key_t q_key,
	input  logic              q_ready
);
	import aks_pkg::*;

	localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

	aks_key_t         slot_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             push;
	logic             pop;

	assign keys.ready = (count_q != CNT_FULL);
	assign push       = keys.valid && keys.ready;
	assign q_valid    = (count_q != '0);
	assign pop        = q_valid && q_ready;
	assign q_key      = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= '{key_high: keys.key_high, key_low: keys.key_low};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : PTR_W'(wr_ptr_q + 1'b1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : PTR_W'(rd_ptr_q + 1'b1);
			end
			case ({push, pop})
				2'b10:   count_q <= CNT_W'(count_q + 1'b1);
				2'b01:   count_q <= CNT_W'(count_q - 1'b1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

>>> design/aks_expand.sv
// aks_expand: round key engine, one round key per cycle into an output register unless the receiver stalls.
// Depends on aks_pkg and aks_rk_if.
module aks_expand (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_valid,
	input  aks_pkg::aks_key_t q_key,
	output logic              q_ready,
	aks_rk_if.source          round_keys
);
	import aks_pkg::*;

	logic [127:0]            w_q;
	logic [AKS_ROUND_W-1:0]  rnd_q;
	logic                    busy_q;
	logic                    out_valid_q;
	logic [AKS_ROUND_W-1:0]  out_rnd_q;
	logic [127:0]            out_key_q;

	logic                    adv;
	logic [31:0]             w0, w1, w2, w3, t;
	logic [31:0]             n0, n1, n2, n3;
	logic [127:0]            next_w;
	logic [AKS_ROUND_W-1:0]  next_rnd;

	assign adv     = !out_valid_q || round_keys.ready;
	assign q_ready = adv && !busy_q;

	always_comb begin
		{w0, w1, w2, w3} = w_q;
		// RotWord then SubWord, round constant in the top byte
		t = {AKS_SBOX[w3[23:16]], AKS_SBOX[w3[15:8]], AKS_SBOX[w3[7:0]], AKS_SBOX[w3[31:24]]}
			^ {aks_rcon(rnd_q), 24'h000000};
		n0 = w0 ^ t;
		n1 = w1 ^ n0;
		n2 = w2 ^ n1;
		n3 = w3 ^ n2;
		next_w   = {n0, n1, n2, n3};
		next_rnd = AKS_ROUND_W'(rnd_q + 1'b1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
			rnd_q       <= AKS_ROUND_FIRST;
		end else if (adv) begin
			if (busy_q) begin
				rnd_q       <= next_rnd;
				busy_q      <= (next_rnd != AKS_ROUND_LAST);
				out_valid_q <= 1'b1;
			end else if (q_valid) begin
				rnd_q       <= AKS_ROUND_FIRST;
				busy_q      <= 1'b1;
				out_valid_q <= 1'b1;
			end else begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (busy_q) begin
				w_q       <= next_w;
				out_key_q <= next_w;
				out_rnd_q <= next_rnd;
			end else if (q_valid) begin
				w_q       <= {q_key.key_high, q_key.key_low};
				out_key_q <= {q_key.key_high, q_key.key_low};
				out_rnd_q <= AKS_ROUND_FIRST;
			end
		end
	end

	assign round_keys.valid          = out_valid_q;
	assign round_keys.round_number   = out_rnd_q;
	assign round_keys.round_key_high = out_key_q[127:64];
	assign round_keys.round_key_low  = out_key_q[63:0];
	assign round_keys.final_round    = (out_rnd_q == AKS_ROUND_LAST);

endmodule

>>> design/aes128_key_schedule.sv
// aes128_key_schedule: AES-128 key expansion, eleven round keys per cipher key.
// Round 0 passes the front queue and the engine's output register after its key request
// is taken; rounds 1..10 follow one a cycle unless the receiver stalls. The engine takes
// a new key once round 10 of the last has left, and a queue of QUEUE_DEPTH keys sits ahead of it.
// Reset: arst_n asynchronous, active low; empties the queue and the output register.
module aes128_key_schedule #(
	parameter int unsigned QUEUE_DEPTH = aks_pkg::AKS_QUEUE_DEPTH
) (
	input  logic     clk,
	input  logic     arst_n,
	aks_key_if.sink  keys,
	aks_rk_if.source round_keys
);
	import aks_pkg::*;

	// front to back queue handshake
	logic     q_valid;
	logic     q_ready;
	aks_key_t q_key;

	// Front: accepts key requests into the queue so a new key can be taken
	// while the engine is still running through the rounds of the last one.
	aks_front #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.keys    (keys),
		.q_valid (q_valid),
		.q_key   (q_key),
		.q_ready (q_ready)
	);

	// Back: expansion engine. Pops a key only after round 10 of the previous
	// one has left for the output register, so results stay in order.
	aks_expand u_expand (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_valid    (q_valid),
		.q_key      (q_key),
		.q_ready    (q_ready),
		.round_keys (round_keys)
	);

	// Rounds of one key come back to back: a taken round below 10 is followed
	// at once by the next round.
	a_round_follows: assert property (@(posedge clk) disable iff (!arst_n)
		round_keys.valid && round_keys.ready && !round_keys.final_round
		|=> round_keys.valid
			&& round_keys.round_number == AKS_ROUND_W'($past(round_keys.round_number) + 1'b1))
		else $error("round key sequence broken");

	// Round numbers never pass the last round.
	a_round_range: assert property (@(posedge clk) disable iff (!arst_n)
		round_keys.valid |-> round_keys.round_number <= AKS_ROUND_LAST)
		else $error("round number out of range");

	// The engine never takes a new key while an expansion is mid-flight.
	a_pop_between_keys: assert property (@(posedge clk) disable iff (!arst_n)
		q_valid && q_ready && round_keys.valid
		|-> round_keys.final_round)
		else $error("key taken during expansion");

endmodule

>>> test/aks_expansion_check.sv
// aks_expansion_check: predicts the eleven round keys of every cipher key request
// and compares them, in order, with the round key channel. Read-only observer.
// Depends on aks_pkg for widths and on aks_key_if / aks_rk_if for the channels.
module aks_expansion_check (
	input  logic        clk,
	input  logic        arst_n,
	aks_key_if          keys,
	aks_rk_if           round_keys,
	output int unsigned mismatches,
	output int unsigned outstanding,
	output int unsigned keys_taken,
	output int unsigned round_keys_taken
);
	import aks_pkg::*;

	typedef struct packed {
		logic [AKS_ROUND_W-1:0] round_number;
		logic [AKS_HALF_W-1:0]  high;
		logic [AKS_HALF_W-1:0]  low;
		logic                   final_flag;
	} round_key_t;

	round_key_t due_round_keys[$];
	logic [7:0] sub_table [256];

	function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
		logic [7:0] acc;
		logic [7:0] x;
		int         i;
		acc = 8'h00;
		x   = a;
		for (i = 0; i < 8; i++) begin
			if (b[i])
				acc ^= x;
			x = {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
		end
		return acc;
	endfunction

	// S-box built from first principles: GF(2^8) inverse, then the affine map
	initial begin
		logic [7:0] inv;
		int         x;
		int         y;
		for (x = 0; x < 256; x++) begin
			inv = 8'h00;
			for (y = 1; y < 256; y++)
				if (gf_mul(x[7:0], y[7:0]) == 8'h01)
					inv = y[7:0];
			sub_table[x] = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]}
				^ {inv[4:0], inv[7:5]} ^ {inv[3:0], inv[7:4]} ^ 8'h63;
		end
	end

	function automatic void expand_cipher_key(input logic [63:0] kh, input logic [63:0] kl);
		logic [31:0] w0, w1, w2, w3, rot, mix;
		logic [7:0]  rc;
		round_key_t  rk;
		int          n;
		w0 = kh[63:32];
		w1 = kh[31:0];
		w2 = kl[63:32];
		w3 = kl[31:0];
		rc = 8'h01;
		for (n = 0; n <= int'(AKS_ROUND_LAST); n++) begin
			if (n != 0) begin
				rot = {w3[23:0], w3[31:24]};
				mix = {sub_table[rot[31:24]], sub_table[rot[23:16]],
					sub_table[rot[15:8]], sub_table[rot[7:0]]} ^ {rc, 24'h000000};
				rc  = {rc[6:0], 1'b0} ^ (rc[7] ? 8'h1b : 8'h00);
				w0 ^= mix;
				w1 ^= w0;
				w2 ^= w1;
				w3 ^= w2;
			end
			rk.round_number = n[AKS_ROUND_W-1:0];
			rk.high         = {w0, w1};
			rk.low          = {w2, w3};
			rk.final_flag   = (n == int'(AKS_ROUND_LAST));
			due_round_keys.push_back(rk);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		round_key_t  want;
		int unsigned bad;
		if (!arst_n) begin
			due_round_keys.delete();
			mismatches       <= 0;
			outstanding      <= 0;
			keys_taken       <= 0;
			round_keys_taken <= 0;
		end else begin
			bad = 0;
			if (keys.valid && keys.ready) begin
				expand_cipher_key(keys.key_high, keys.key_low);
				keys_taken <= keys_taken + 1;
			end
			if (round_keys.valid && round_keys.ready) begin
				round_keys_taken <= round_keys_taken + 1;
				if (due_round_keys.size() == 0) begin
					$error("round key request with nothing due: round_number %0d",
						round_keys.round_number);
					bad++;
				end else begin
					want = due_round_keys.pop_front();
					if (round_keys.round_number !== want.round_number) begin
						$error("round_number: expected %0d, actual %0d",
							want.round_number, round_keys.round_number);
						bad++;
					end
					if (round_keys.round_key_high !== want.high) begin
						$error("round_key_high: expected %h, actual %h",
							want.high, round_keys.round_key_high);
						bad++;
					end
					if (round_keys.round_key_low !== want.low) begin
						$error("round_key_low: expected %h, actual %h",
							want.low, round_keys.round_key_low);
						bad++;
					end
					if (round_keys.final_round !== want.final_flag) begin
						$error("final_round: expected %0b, actual %0b",
							want.final_flag, round_keys.final_round);
						bad++;
					end
				end
			end
			mismatches  <= mismatches + bad;
			outstanding <= due_round_keys.size();
		end
	end

endmodule

>>> test/tb.sv
// tb: drives cipher key requests into aes128_key_schedule and gives the verdict.
// Depends on aks_pkg, the aks_if channels and aks_expansion_check for prediction.
module tb;
	import aks_pkg::*;

	// Quiet-cycle limit: well beyond the longest deliberate hold-off, LONG_HOLD; random stalls
	// at 60% add short runs only, so this leaves a wide margin.
	localparam int unsigned QUIET_LIMIT  = 2000;
	localparam int unsigned LONG_HOLD    = 300;
	// Extra settle time after the last drain, before the verdict.
	localparam int unsigned TAIL_CYCLES  = 16;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	aks_key_if key_chan ();
	aks_rk_if  rk_chan ();

	int unsigned tx_idle_pct  = 0;
	int unsigned rx_stall_pct = 0;
	int unsigned hold_len     = 0;
	int unsigned hold_seq     = 0;
	int unsigned quiet_cycles = 0;

	int unsigned mismatches;
	int unsigned outstanding;
	int unsigned keys_taken;
	int unsigned round_keys_taken;

	aes128_key_schedule DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.keys       (key_chan),
		.round_keys (rk_chan)
	);

	aks_expansion_check expansion_check (
		.clk              (clk),
		.arst_n           (arst_n),
		.keys             (key_chan),
		.round_keys       (rk_chan),
		.mismatches       (mismatches),
		.outstanding      (outstanding),
		.keys_taken       (keys_taken),
		.round_keys_taken (round_keys_taken)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Round key receiver. A hold-off is requested by bumping hold_seq; the length
	// is then counted down here, so only this process owns the counter.
	int unsigned hold_left = 0;
	int unsigned hold_seen = 0;
	always @(posedge clk) begin
		if (!arst_n) begin
			rk_chan.ready <= 1'b0;
		end else begin
			if (hold_seq != hold_seen) begin
				hold_seen = hold_seq;
				hold_left = hold_len;
			end
			if (hold_left != 0) begin
				hold_left--;
				rk_chan.ready <= 1'b0;
			end else begin
				rk_chan.ready <= ($urandom_range(99) >= rx_stall_pct);
			end
		end
	end

	// Watchdog: any request on either channel resets the quiet count.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((key_chan.valid && key_chan.ready) || (rk_chan.valid && rk_chan.ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("watchdog: no request for %0d cycles", quiet_cycles);
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	// One key request. Idle cycles come first, so valid is only ever lowered or
	// raised once per edge, and stays high across back-to-back requests.
	task automatic send_key(input logic [63:0] kh, input logic [63:0] kl);
		while ($urandom_range(99) < tx_idle_pct) begin
			key_chan.valid <= 1'b0;
			@(posedge clk);
		end
		key_chan.valid    <= 1'b1;
		key_chan.key_high <= kh;
		key_chan.key_low  <= kl;
		do @(posedge clk); while (!key_chan.ready);
	endtask

	// Drop valid and wait for every due round key. The first edge lets the
	// checker's count catch up with the request just taken.
	task automatic wait_drained();
		key_chan.valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	// Mostly uniform keys; now and then a zero half, an all-ones half or a
	// sparse pattern to push unusual words through the S-box.
	function automatic logic [127:0] random_key();
		logic [127:0] k;
		k = {$urandom, $urandom, $urandom, $urandom};
		case ($urandom_range(9))
			0:       k[127:64] = '0;
			1:       k[63:0]   = '1;
			2:       k         = k & {$urandom, $urandom, $urandom, $urandom};
			default: ;
		endcase
		return k;
	endfunction

	task automatic run_phase(input int unsigned count, input int unsigned tx_pct,
		input int unsigned rx_pct);
		logic [127:0] k;
		tx_idle_pct  = tx_pct;
		rx_stall_pct <= rx_pct;
		repeat (count) begin
			k = random_key();
			send_key(k[127:64], k[63:0]);
		end
	endtask

	initial begin
		key_chan.valid    = 1'b0;
		key_chan.key_high = '0;
		key_chan.key_low  = '0;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed keys, no idling: extremes, the standard example key, counting bytes,
		// alternating bits, half-ones keys, single set bits at each end and mixed patterns.
		send_key(64'h0000000000000000, 64'h0000000000000000);
		send_key(64'hffffffffffffffff, 64'hffffffffffffffff);
		send_key(64'h2b7e151628aed2a6, 64'habf7158809cf4f3c);
		send_key(64'h0001020304050607, 64'h08090a0b0c0d0e0f);
		send_key(64'h5555555555555555, 64'haaaaaaaaaaaaaaaa);
		send_key(64'haaaaaaaaaaaaaaaa, 64'h5555555555555555);
		send_key(64'hffffffffffffffff, 64'h0000000000000000);
		send_key(64'h0000000000000000, 64'hffffffffffffffff);
		send_key(64'h8000000000000000, 64'h0000000000000000);
		send_key(64'h0000000000000000, 64'h0000000000000001);
		send_key(64'h0123456789abcdef, 64'hfedcba9876543210);
		send_key(64'h00000000000000ff, 64'hff000000000000ff);

		// Random keys under each idling mix.
		run_phase(30, 0, 0);
		run_phase(25, 60, 0);
		run_phase(25, 0, 60);
		run_phase(30, 23, 23);

		// Back-pressure: receiver holds off while keys keep coming, so the
		// queue ahead of the engine fills and the key channel stalls.
		hold_len <= LONG_HOLD;
		hold_seq <= hold_seq + 1;
		run_phase(10, 0, 0);

		// Sender pause until everything due has arrived, then a last mix.
		wait_drained();
		run_phase(10, 23, 23);

		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Run covered %0d cipher key requests and %0d round key requests,",
			keys_taken, round_keys_taken);
		$display("with free-running, idle, stalled, held-off and paused phases.");
		if (mismatches == 0 && outstanding == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

>>> filelist.f
design/aks_pkg.sv
design/aks_if.sv
design/aks_front.sv
design/aks_expand.sv
design/aes128_key_schedule.sv
test/aks_expansion_check.sv
test/tb.sv
